// ===== design/t2u_pkg.sv =====
// shared types, constants and the bit-doubling function of the 2x tile upscaler
package t2u_pkg;

  localparam int unsigned TILE_BYTES = 16;
  localparam int unsigned TDATA_IN_W = 32;
  localparam int unsigned IDX_W      = 13;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_MEM,
    ST_OUT
  } t2u_state_e;

  // read-side tile decode handed from the address mapper to the top level
  typedef struct packed {
    logic hit;
    logic odd_col;
  } t2u_rd_t;

  function automatic logic [7:0] widen_nibble(input logic [3:0] nib);
    logic [7:0] r;
    r = '0;
    for (int b = 0; b < 4; b++) begin
      r[2*b]   = nib[b];
      r[2*b+1] = nib[b];
    end
    return r;
  endfunction

endpackage

// ===== design/t2u_store.sv =====
// source tile store: single port synchronous ram with registered read data
module t2u_store #(
  parameter int unsigned DEPTH = 192,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/t2u_addr_map.sv =====
// maps an output byte address to the source byte index, one register stage
module t2u_addr_map #(
  parameter int unsigned SRC_TILES_W = 6,
  parameter int unsigned SRC_TILES_H = 2,
  parameter int unsigned AW          = 8
) (
  input  logic                 clk_i,
  input  logic                 calc_en_i,
  input  logic [9:0]           out_addr_i,
  output t2u_pkg::t2u_rd_t     rd_o,
  output logic [AW-1:0]        sidx_o
);

  import t2u_pkg::*;

  localparam int unsigned MapW     = SRC_TILES_W * 2;
  localparam int unsigned OutTiles = SRC_TILES_W * SRC_TILES_H * 4;

  logic [4:0] ty_tab [64];
  logic [4:0] tx_tab [64];

  // tile -> (column, row) on the output map, worked out at elaboration
  for (genvar i = 0; i < 64; i++) begin : g_tab
    assign ty_tab[i] = 5'(i / MapW);
    assign tx_tab[i] = 5'(i % MapW);
  end

  logic [5:0]  tile;
  logic [4:0]  tx_q, ty_q;
  logic [2:0]  row_q;
  logic        plane_q;
  logic        hit_q;
  logic [IDX_W-1:0] src_tile;
  logic [IDX_W-1:0] sidx;

  assign tile = out_addr_i[9:4];

  always_ff @(posedge clk_i) begin
    if (calc_en_i) begin
      tx_q    <= tx_tab[tile];
      ty_q    <= ty_tab[tile];
      row_q   <= out_addr_i[3:1];
      plane_q <= out_addr_i[0];
      hit_q   <= (IDX_W'(tile) < IDX_W'(OutTiles));
    end
  end

  // source row within the tile is (ty odd) * 4 + row / 2
  always_comb begin
    src_tile = IDX_W'(ty_q[4:1]) * IDX_W'(SRC_TILES_W) + IDX_W'(tx_q[4:1]);
    sidx     = (src_tile << 4) + IDX_W'({ty_q[0], row_q[2:1], plane_q});
  end

  assign sidx_o      = sidx[AW-1:0];
  assign rd_o.hit     = hit_q;
  assign rd_o.odd_col = tx_q[0];

endmodule

// ===== design/tile_2bpp_upscale_2x.sv =====
// top level of the nearest-neighbor 2x upscaler for planar 2bpp tiles
//
// input stream: each beat is one operation. tuser = 0 writes write_data into
// the source store at src_addr (tile*16 + row*2 + plane); tuser = 1 reads the
// output byte at out_addr of the doubled image, whose tiles run row-major
// across a map twice the source width. every beat yields one output beat:
// the scaled byte on a read, zero on a write. a write past the store is
// dropped, a read past the output image returns zero.
// timing: an item goes through accept, tile decode (table lookup),
// store access on the single ram port, then load of the output register.
// the block takes no new item until the last one has been loaded into the
// output register.
// items run one at a time through the store, so a read always sees an
// earlier write to the same byte.
// reset clears the control state and the output valid; store contents are
// undefined until written. while the receiver stalls the result waits in
// the output register; the next item may still be accepted and is held at
// its last step until the output register frees up.
module tile_2bpp_upscale_2x #(
  parameter int unsigned SRC_TILES_W = 6,
  parameter int unsigned SRC_TILES_H = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] src_addr, [15:8] write_data, [25:16] out_addr, [31:26] zero
  input  logic [t2u_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
  // [0] op
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] read_data
  output logic [7:0]                        m_axis_tdata
);

  import t2u_pkg::*;

  localparam int unsigned StoreBytes = SRC_TILES_W * SRC_TILES_H * TILE_BYTES;
  localparam int unsigned AW         = $clog2(StoreBytes);

  t2u_state_e state_q, state_d;

  logic        op_q;
  logic [7:0]  saddr_q, wdata_q;
  logic [9:0]  oaddr_q;
  logic        out_vld_q, out_vld_d;
  logic [7:0]  out_data_q, out_data_d;

  logic        in_fire, out_free;
  logic        calc_en, mem_en, mem_we;
  logic        saddr_ok;
  logic [AW-1:0]    mem_addr, sidx;
  logic [IDX_W-1:0] saddr_ext;
  logic [7:0]  rdata, result;
  logic [3:0]  nib;
  t2u_rd_t     rd;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= s_axis_tuser;
      saddr_q <= s_axis_tdata[7:0];
      wdata_q <= s_axis_tdata[15:8];
      oaddr_q <= s_axis_tdata[25:16];
    end
  end

  t2u_addr_map #(
    .SRC_TILES_W (SRC_TILES_W),
    .SRC_TILES_H (SRC_TILES_H),
    .AW          (AW)
  ) u_addr_map (
    .clk_i      (clk_i),
    .calc_en_i  (calc_en),
    .out_addr_i (oaddr_q),
    .rd_o       (rd),
    .sidx_o     (sidx)
  );

  assign saddr_ext = IDX_W'(saddr_q);
  assign saddr_ok  = saddr_ext < IDX_W'(StoreBytes);
  assign mem_addr  = op_q ? sidx : saddr_ext[AW-1:0];
  assign mem_we    = mem_en && !op_q && saddr_ok;

  t2u_store #(
    .DEPTH (StoreBytes),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (wdata_q),
    .rdata_o (rdata)
  );

  // even output columns take the high nibble
  assign nib    = rd.odd_col ? rdata[3:0] : rdata[7:4];
  assign result = (op_q && rd.hit) ? widen_nibble(nib) : 8'h00;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  always_comb begin
    state_d    = state_q;
    calc_en    = 1'b0;
    mem_en     = 1'b0;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        calc_en = 1'b1;
        state_d = ST_MEM;
      end
      ST_MEM: begin
        mem_en  = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = result;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
